### src/cfp_pkg.sv
// shared types and codes of the command frame parser
package cfp_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        REG_SET_HEADER      = 2'd0,
        REG_GET_HEADER      = 2'd1,
        REG_SET_ONCE_HEADER = 2'd2,
        REG_PARAM_LIMIT     = 2'd3
    } reg_index_t;

    localparam logic [1:0] FRAME_SET      = 2'd0;
    localparam logic [1:0] FRAME_GET      = 2'd1;
    localparam logic [1:0] FRAME_SET_ONCE = 2'd2;

    localparam logic [1:0] OUT_FRAME = 2'd0;
    localparam logic [1:0] OUT_ABORT = 2'd1;
    localparam logic [1:0] OUT_DROP  = 2'd2;

    localparam int HEADER_BYTES = 3;
    localparam logic [5:0] LIMIT_CAP = 6'd60;

endpackage

### src/config_command_frame_parser.sv
// command frame parser: input channel, frame store and result drain
//
// Input: one received byte per beat on in_valid/in_ready/rx_byte. While idle
// a byte equal to a header register opens a frame; any other byte is dropped
// and reported as one result beat. Bytes of a frame go into the frame store
// (a one-port-write, one-port-read synchronous memory of BUFFER_DEPTH bytes).
// Output: result beats on out_valid/out_ready with kind, frame_byte and
// last_of_run. A finished frame of n bytes is read back from the store one
// byte per cycle through a registered read while the output is free; no byte
// is taken while a frame drains. Other bytes go in one per cycle likewise.
// Drop and abort results leave in the cycle after the byte that caused them.
// When out_ready is low the output register holds its beat, the drain pauses
// at the memory read, and in_ready falls until the held beat is taken.
// Configuration: wr_en/wr_index/wr_data write the header bytes and parameter
// limit; the user must write them only while the block is idle (unenforced).
// Reset: registers return to 192, 193, 194 and 9, the parser goes idle and
// the output is empty; the frame store is not cleared and needs no pass.
module config_command_frame_parser #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [7:0] wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] frame_byte,
    output logic       last_of_run
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = AW + 1;

    cfp_pkg::state_t state_reg, state_next;

    logic [7:0] set_header_reg;
    logic [7:0] get_header_reg;
    logic [7:0] set_once_header_reg;
    logic [5:0] param_limit_reg;

    logic [1:0]    frame_kind_reg;
    logic [AW-1:0] count_reg;
    logic [7:0]    plen_reg;
    logic [AW-1:0] drain_len_reg;
    logic [AW-1:0] rd_idx_reg;

    logic       out_valid_reg;
    logic [1:0] out_kind_reg;
    logic [7:0] stat_byte_reg;
    logic       out_last_reg;

    logic [7:0] frame_store [BUFFER_DEPTH];
    logic [7:0] mem_q;

    logic          out_free;
    logic          accept;
    logic          rd_en;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CW-1:0] count_new;
    logic [5:0]    limit;
    logic          hdr_hit;
    logic [1:0]    hdr_kind;
    logic          done;
    logic          fail;
    logic          third;
    logic          rd_last;

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign limit    = (param_limit_reg > cfp_pkg::LIMIT_CAP) ? cfp_pkg::LIMIT_CAP
                                                             : param_limit_reg;
    assign count_new = CW'(count_reg) + CW'(1);
    assign third     = (count_new == CW'(cfp_pkg::HEADER_BYTES));
    assign rd_last   = (CW'(rd_idx_reg) + CW'(1)) == CW'(drain_len_reg);

    // header match, tried in register order
    always_comb
    begin
        hdr_hit  = 1'b1;
        hdr_kind = cfp_pkg::FRAME_SET;
        if (rx_byte == set_header_reg)
        begin
            hdr_kind = cfp_pkg::FRAME_SET;
        end
        else if (rx_byte == get_header_reg)
        begin
            hdr_kind = cfp_pkg::FRAME_GET;
        end
        else if (rx_byte == set_once_header_reg)
        begin
            hdr_kind = cfp_pkg::FRAME_SET_ONCE;
        end
        else
        begin
            hdr_hit = 1'b0;
        end
    end

    // end and abort decisions for a byte inside a frame
    always_comb
    begin
        done = 1'b0;
        fail = 1'b0;
        if (frame_kind_reg == cfp_pkg::FRAME_GET)
        begin
            done = third;
        end
        else if (third)
        begin
            if (rx_byte > {2'b00, limit})
            begin
                fail = 1'b1;
            end
            else if (rx_byte == 8'd0)
            begin
                done = 1'b1;
            end
        end
        else if ((10'(plen_reg) + 10'(cfp_pkg::HEADER_BYTES)) == 10'(count_new))
        begin
            done = 1'b1;
        end
        if (count_new >= CW'(BUFFER_DEPTH))
        begin
            fail = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfp_pkg::ST_IDLE:
            begin
                if (accept && hdr_hit)
                begin
                    state_next = cfp_pkg::ST_COLLECT;
                end
            end
            cfp_pkg::ST_COLLECT:
            begin
                if (accept && fail)
                begin
                    state_next = cfp_pkg::ST_IDLE;
                end
                else if (accept && done)
                begin
                    state_next = cfp_pkg::ST_DRAIN;
                end
            end
            cfp_pkg::ST_DRAIN:
            begin
                if (rd_en && rd_last)
                begin
                    state_next = cfp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfp_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = count_reg;
        unique case (state_reg)
            cfp_pkg::ST_IDLE:
            begin
                in_ready  = out_free;
                mem_we    = accept && hdr_hit;
                mem_waddr = '0;
            end
            cfp_pkg::ST_COLLECT:
            begin
                in_ready = out_free;
                mem_we   = accept;
            end
            cfp_pkg::ST_DRAIN:
            begin
                rd_en = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_header_reg      <= 8'd192;
            get_header_reg      <= 8'd193;
            set_once_header_reg <= 8'd194;
            param_limit_reg     <= 6'd9;
        end
        else if (wr_en)
        begin
            unique case (cfp_pkg::reg_index_t'(wr_index))
                cfp_pkg::REG_SET_HEADER:      set_header_reg      <= wr_data;
                cfp_pkg::REG_GET_HEADER:      get_header_reg      <= wr_data;
                cfp_pkg::REG_SET_ONCE_HEADER: set_once_header_reg <= wr_data;
                cfp_pkg::REG_PARAM_LIMIT:     param_limit_reg     <= wr_data[5:0];
                default:                      param_limit_reg     <= param_limit_reg;
            endcase
        end
    end

    // frame bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_kind_reg <= cfp_pkg::FRAME_SET;
            count_reg      <= '0;
            plen_reg       <= '0;
            drain_len_reg  <= '0;
            rd_idx_reg     <= '0;
        end
        else
        begin
            if (accept && state_reg == cfp_pkg::ST_IDLE && hdr_hit)
            begin
                frame_kind_reg <= hdr_kind;
                count_reg      <= AW'(1);
                plen_reg       <= '0;
            end
            else if (accept && state_reg == cfp_pkg::ST_COLLECT)
            begin
                if (fail || done)
                begin
                    count_reg <= '0;
                    plen_reg  <= '0;
                end
                else
                begin
                    count_reg <= count_new[AW-1:0];
                    if (third)
                    begin
                        plen_reg <= rx_byte;
                    end
                end
                if (done && !fail)
                begin
                    drain_len_reg <= count_new[AW-1:0];
                    rd_idx_reg    <= '0;
                end
            end
            else if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
        end
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_store[mem_waddr] <= rx_byte;
        end
        if (rd_en)
        begin
            mem_q <= frame_store[rd_idx_reg];
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_kind_reg  <= cfp_pkg::OUT_FRAME;
            out_last_reg  <= 1'b0;
        end
        else if (rd_en)
        begin
            out_valid_reg <= 1'b1;
            out_kind_reg  <= cfp_pkg::OUT_FRAME;
            out_last_reg  <= rd_last;
        end
        else if (accept && state_reg == cfp_pkg::ST_IDLE && !hdr_hit)
        begin
            out_valid_reg <= 1'b1;
            out_kind_reg  <= cfp_pkg::OUT_DROP;
            out_last_reg  <= 1'b1;
        end
        else if (accept && state_reg == cfp_pkg::ST_COLLECT && fail)
        begin
            out_valid_reg <= 1'b1;
            out_kind_reg  <= cfp_pkg::OUT_ABORT;
            out_last_reg  <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // status byte: the dropped byte, or zero on abort
    always_ff @(posedge clk)
    begin
        if (accept && state_reg == cfp_pkg::ST_IDLE)
        begin
            stat_byte_reg <= rx_byte;
        end
        else if (accept)
        begin
            stat_byte_reg <= 8'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign last_of_run = out_last_reg;
    assign frame_byte  = (out_kind_reg == cfp_pkg::OUT_FRAME) ? mem_q : stat_byte_reg;

endmodule

### tb/sv/tb_config_command_frame_parser.sv
`timescale 1ns / 1ps
// testbench of the command frame parser: header matching, frame lengths, aborts, drops, stalls
module tb_config_command_frame_parser;

    localparam int DEPTH = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } parse_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       wr_en = 1'b0;
    logic [1:0] wr_index = '0;
    logic [7:0] wr_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] frame_byte;
    logic       last_of_run;

    // parser state as the testbench sees it
    logic [7:0] set_hdr = 8'd192;
    logic [7:0] get_hdr = 8'd193;
    logic [7:0] once_hdr = 8'd194;
    logic [5:0] limit_reg = 6'd9;
    bit         in_frame = 1'b0;
    logic [1:0] cur_frame = cfp_pkg::FRAME_SET;
    int         count = 0;
    int         plen = 0;
    logic [7:0] store [DEPTH];
    parse_result_t results_due [$];
    parse_result_t want;

    int bytes_sent = 0;
    int mismatches = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int quiet = 0;

    config_command_frame_parser u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .frame_byte  (frame_byte),
        .last_of_run (last_of_run)
    );

    always #10 clk = ~clk;

    function automatic int eff_limit();
        return (limit_reg > cfp_pkg::LIMIT_CAP) ? int'(cfp_pkg::LIMIT_CAP) : int'(limit_reg);
    endfunction

    function automatic void push_result(input logic [1:0] k, input logic [7:0] d,
                                        input logic l);
        parse_result_t r;
        r.kind = k;
        r.data = d;
        r.last = l;
        results_due.push_back(r);
    endfunction

    function automatic void predict_frame_results(input logic [7:0] b);
        int  lim;
        bit  done;
        bit  fail;
        lim = eff_limit();
        done = 1'b0;
        fail = 1'b0;
        if (!in_frame)
        begin
            // priority on equal headers: set, then get, then set-once
            if (b == set_hdr)
                cur_frame = cfp_pkg::FRAME_SET;
            else if (b == get_hdr)
                cur_frame = cfp_pkg::FRAME_GET;
            else if (b == once_hdr)
                cur_frame = cfp_pkg::FRAME_SET_ONCE;
            else
            begin
                push_result(cfp_pkg::OUT_DROP, b, 1'b1);
                return;
            end
            store[0] = b;
            count = 1;
            plen = 0;
            in_frame = 1'b1;
            return;
        end
        if (count < DEPTH)
            store[count] = b;
        count++;
        if (cur_frame == cfp_pkg::FRAME_GET)
            done = (count == cfp_pkg::HEADER_BYTES);
        else if (count == cfp_pkg::HEADER_BYTES)
        begin
            plen = b;
            if (plen > lim)
                fail = 1'b1;
            else if (plen == 0)
                done = 1'b1;
        end
        else if (plen + cfp_pkg::HEADER_BYTES == count)
            done = 1'b1;
        if (count >= DEPTH)
            fail = 1'b1;
        if (fail)
        begin
            push_result(cfp_pkg::OUT_ABORT, 8'h00, 1'b1);
            in_frame = 1'b0;
            count = 0;
            plen = 0;
        end
        else if (done)
        begin
            for (int i = 0; i < count; i++)
                push_result(cfp_pkg::OUT_FRAME, store[i], i == count - 1);
            in_frame = 1'b0;
            count = 0;
            plen = 0;
        end
    endfunction

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result beat with none expected: kind %0d byte %h last %b",
                         $time, kind, frame_byte, last_of_run);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d, got %0d", $time, want.kind, kind);
                    mismatches++;
                end
                if (frame_byte !== want.data)
                begin
                    $display("%0t: frame_byte expected %h, got %h", $time, want.data,
                             frame_byte);
                    mismatches++;
                end
                if (last_of_run !== want.last)
                begin
                    $display("%0t: last_of_run expected %b, got %b", $time, want.last,
                             last_of_run);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("** config_command_frame_parser: FAILED **");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predict_frame_results(b);
        bytes_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // header, one byte, then either a get tail or a length and its parameters
    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] len_byte);
        send_byte(hdr);
        if (!in_frame)
            return;
        send_byte(8'($urandom_range(255)));
        if (cur_frame == cfp_pkg::FRAME_GET)
        begin
            send_byte(8'($urandom_range(255)));
            return;
        end
        send_byte(len_byte);
        while (in_frame)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic finish_frame();
        while (in_frame)
            send_byte(8'h00);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfp_pkg::reg_index_t idx, input logic [7:0] v);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= v;
        @(posedge clk);
        case (idx)
            cfp_pkg::REG_SET_HEADER:      set_hdr = v;
            cfp_pkg::REG_GET_HEADER:      get_hdr = v;
            cfp_pkg::REG_SET_ONCE_HEADER: once_hdr = v;
            cfp_pkg::REG_PARAM_LIMIT:     limit_reg = v[5:0];
        endcase
    endtask

    task automatic configure(input logic [7:0] sh, input logic [7:0] gh,
                             input logic [7:0] oh, input logic [7:0] lim);
        finish_frame();
        wait_drain();
        write_reg(cfp_pkg::REG_SET_HEADER, sh);
        write_reg(cfp_pkg::REG_GET_HEADER, gh);
        write_reg(cfp_pkg::REG_SET_ONCE_HEADER, oh);
        write_reg(cfp_pkg::REG_PARAM_LIMIT, lim);
        wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_header();
        case ($urandom_range(2))
            0:       return set_hdr;
            1:       return get_hdr;
            default: return once_hdr;
        endcase
    endfunction

    task automatic test_reset_defaults();
        idle_pct = 0;
        stall_pct = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        // get frame carrying header values as data
        send_byte(8'd193);
        send_byte(8'd192);
        send_byte(8'd194);
        // zero length set frame ends at its third byte
        send_byte(8'd192);
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'd194);
        send_byte(8'h3C);
        send_byte(8'h02);
        send_byte(8'hC3);
        send_byte(8'h81);
        // length one above the limit aborts
        send_byte(8'd192);
        send_byte(8'h7E);
        send_byte(8'd10);
        send_byte(8'd193);
        send_byte(8'h01);
        send_byte(8'hFE);
    endtask

    task automatic test_config_extremes();
        // all headers equal: set wins; limit 63 saturates to 60
        configure(8'h00, 8'h00, 8'h00, 8'd63);
        send_frame(8'h00, 8'd60);
        send_frame(8'h00, 8'd61);
        send_byte(8'hFF);
        configure(8'hFF, 8'hFF, 8'hFF, 8'd0);
        send_frame(8'hFF, 8'd0);
        send_frame(8'hFF, 8'd1);
        send_byte(8'h00);
        // upper data bits of the limit write are not kept
        configure(8'hA0, 8'hA0, 8'hA1, 8'hC9);
        send_frame(8'hA0, 8'd9);
        send_frame(8'hA1, 8'd9);
        send_frame(8'hA1, 8'd10);
        // get and set-once equal: get wins
        configure(8'h10, 8'h20, 8'h20, 8'd61);
        send_frame(8'h20, 8'd5);
        send_frame(8'h10, 8'd61);
        send_frame(8'h10, 8'd62);
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int n);
        int          stop_at;
        int          pick;
        int          lim;
        logic [7:0]  sh;
        idle_pct = idle;
        stall_pct = stall;
        sh = 8'($urandom_range(255));
        if ($urandom_range(3) == 0)
            configure(sh, sh, 8'($urandom_range(255)), 8'($urandom_range(63)));
        else
            configure(sh, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(63)));
        lim = eff_limit();
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_byte(8'($urandom_range(255)));
            else if (pick < 18)
                send_frame(pick_header(), 8'($urandom_range(lim + 1, 255)));
            else if (pick < 24)
            begin
                // truncated frame: later bytes run on as its content
                send_byte(pick_header());
                repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
            end
            else if (pick < 85)
                send_frame(pick_header(), 8'($urandom_range(0, (lim < 6) ? lim : 6)));
            else
                send_frame(pick_header(), 8'($urandom_range(0, lim)));
        end
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        configure(8'd192, 8'd193, 8'd194, 8'd20);
        hold_req++;
        repeat (4)
        begin
            send_frame(8'd192, 8'($urandom_range(4, 20)));
            send_byte(8'h33);
            send_frame(8'd193, 8'd0);
        end
        // pause until everything has come out, then resume
        wait_drain();
        stall_pct = 30;
        repeat (3) send_frame(pick_header(), 8'($urandom_range(0, 20)));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_random_traffic(0, 0, 25);
        test_random_traffic(68, 0, 25);
        test_random_traffic(0, 68, 25);
        test_random_traffic(16, 16, 25);
        test_backpressure();
        finish_frame();
        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("** config_command_frame_parser: PASSED **");
        else
            $display("** config_command_frame_parser: FAILED **");
        $finish;
    end

endmodule

### config_command_frame_parser.f
src/cfp_pkg.sv
src/config_command_frame_parser.sv
tb/sv/tb_config_command_frame_parser.sv
